[rtl/core/adl1_pkg.sv]
package adl1_pkg;

  // default vector length
  localparam int ELEM_COUNT_DEF = 4096;

  // update modes
  localparam logic [1:0] MODE_PLAIN     = 2'd0;
  localparam logic [1:0] MODE_L1        = 2'd1;
  localparam logic [1:0] MODE_L1_NONNEG = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_RATE = 2'd1;
  localparam logic [1:0] REG_L1   = 2'd2;

  // item opcodes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // reset values of the registers
  localparam logic [1:0]  MODE_RST = MODE_L1;
  localparam logic [15:0] RATE_RST = 16'd3277;
  localparam logic [31:0] L1_RST   = 32'd32768;

  // gradient sum limits, signed Q32.16
  localparam logic [47:0] GSUM_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] GSUM_MIN = 48'h8000_0000_0000;

  localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_ROOT,
    S_PREP,
    S_DIV,
    S_CALC,
    S_WRITE
  } state_t;

  // write enables of the three element stores
  typedef struct packed {
    logic w;
    logic s;
    logic g;
  } st_we_t;

endpackage

[rtl/core/adl1_store.sv]
module adl1_store #(
  parameter int DEPTH = adl1_pkg::ELEM_COUNT_DEF,
  parameter int AW    = 12
) (
  input  logic            clk,
  input  logic [AW-1:0]   rd_addr,
  input  logic [AW-1:0]   wr_addr,
  input  adl1_pkg::st_we_t we,
  input  logic [31:0]     w_wdata,
  input  logic [63:0]     s_wdata,
  input  logic [47:0]     g_wdata,
  output logic [31:0]     w_rdata,
  output logic [63:0]     s_rdata,
  output logic [47:0]     g_rdata
);

  logic [31:0] w_mem [DEPTH];
  logic [63:0] s_mem [DEPTH];
  logic [47:0] g_mem [DEPTH];

  // weight store
  always_ff @(posedge clk) begin
    if (we.w) begin
      w_mem[wr_addr] <= w_wdata;
    end
    w_rdata <= w_mem[rd_addr];
  end

  // squared gradient sum store
  always_ff @(posedge clk) begin
    if (we.s) begin
      s_mem[wr_addr] <= s_wdata;
    end
    s_rdata <= s_mem[rd_addr];
  end

  // gradient sum store
  always_ff @(posedge clk) begin
    if (we.g) begin
      g_mem[wr_addr] <= g_wdata;
    end
    g_rdata <= g_mem[rd_addr];
  end

endmodule

[rtl/core/adl1_isqrt.sv]
module adl1_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] x_sh;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic        run;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        fit;

  // one result bit per cycle, two radicand bits brought down
  assign rem_sh = {rem, x_sh[63:62]};
  assign trial  = {2'b00, root, 2'b01};
  assign fit    = rem_sh >= trial;
  assign done   = run && (cnt == 5'd31);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_sh <= x;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      x_sh <= {x_sh[61:0], 2'b00};
      rem  <= fit ? 34'(rem_sh - trial) : rem_sh[33:0];
      root <= {root[30:0], fit};
    end
  end

endmodule

[rtl/core/adl1_div.sv]
module adl1_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [31:0] rem;
  logic [31:0] den_r;
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] rem_sh;
  logic        fit;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem, quo[63]};
  assign fit    = rem_sh >= {1'b0, den_r};
  assign done   = run && (cnt == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (run) begin
      rem <= fit ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
      quo <= {quo[62:0], fit};
    end
  end

endmodule

[rtl/core/adagrad_l1_element_update_core.sv]
// Per-element Adagrad / L1 dual averaging update over a stored weight vector.
// Each input beat either loads a weight or applies a Q16.16 gradient to one
// element: the gradient and squared-gradient sums are updated (saturating), a
// square root of the squared sum is taken and the step is divided by it.
// Items are processed one at a time through a read-modify-write of three
// element memories (one read and one write port each, registered read). A
// gradient update runs through accept, a memory read, the bit-serial square
// root, one setup step, the bit-serial divider, forming the weight and the
// write-back; the divider and the forming step are skipped when the L1
// shrinkage zeroes the weight or the squared sum is zero. Load items and
// out-of-range indexes go from the memory read straight to the write-back.
// A full output register adds its stall to the write-back. After reset the
// block clears all ELEM_COUNT elements of the memories and holds in_ready
// low. A finished result waits in an output register while the next beat is
// taken.
module adagrad_l1_element_update_core #(
  parameter int ELEM_COUNT = adl1_pkg::ELEM_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [11:0]        elem_index,
  input  logic signed [31:0] value,
  input  logic               starts_pass,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        out_index,
  output logic signed [31:0] new_weight,
  output logic               zeroed
);

  localparam int AW = (ELEM_COUNT > 1) ? $clog2(ELEM_COUNT) : 1;

  adl1_pkg::state_t state, state_next;

  logic [1:0]  mode_r;
  logic [15:0] rate_r;
  logic [31:0] l1_r;
  logic [31:0] pass_cnt;

  logic        it_op;
  logic [11:0] it_idx;
  logic [31:0] it_val;
  logic [31:0] it_mag;
  logic        it_in_range;
  logic [63:0] sq_r;
  logic [31:0] w_old;
  logic [47:0] gs_r;
  logic [63:0] pen_r;
  logic [31:0] res_w;
  logic        res_zero;
  logic        res_wr;
  logic [AW-1:0] clr_ptr;

  logic        acc;
  logic        out_free;
  logic        is_plain;
  logic        is_nonneg;
  logic        is_update;
  logic [31:0] mag_in;

  adl1_pkg::st_we_t st_we;
  logic [AW-1:0] wr_addr;
  logic [31:0]   w_wdata;
  logic [63:0]   s_wdata;
  logic [47:0]   g_wdata;
  logic [31:0]   w_rd;
  logic [63:0]   s_rd;
  logic [47:0]   g_rd;

  logic [64:0] s_sum;
  logic [63:0] s_new;
  logic [48:0] gs_sum;
  logic [47:0] gs_new;

  logic        sq_start;
  logic        sq_done;
  logic [31:0] root;

  logic [47:0] gs_mag;
  logic        no_gain;
  logic [47:0] diff;
  logic [47:0] mul_a;
  logic [63:0] num;
  logic        div_start;
  logic        div_done;
  logic [63:0] quo;

  logic [65:0] nw;
  logic        l1_neg;
  logic [31:0] w_plain;
  logic [31:0] w_l1;

  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign is_plain  = mode_r == adl1_pkg::MODE_PLAIN;
  assign is_nonneg = mode_r == adl1_pkg::MODE_L1_NONNEG;
  assign is_update = (it_op == adl1_pkg::OP_UPDATE) && it_in_range;
  assign mag_in    = value[31] ? 32'(-value) : value;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r <= adl1_pkg::MODE_RST;
      rate_r <= adl1_pkg::RATE_RST;
      l1_r   <= adl1_pkg::L1_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        adl1_pkg::REG_MODE: mode_r <= cfg_data[1:0];
        adl1_pkg::REG_RATE: rate_r <= cfg_data[15:0];
        adl1_pkg::REG_L1:   l1_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // element memories
  adl1_store #(
    .DEPTH (ELEM_COUNT),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_addr (AW'(elem_index)),
    .wr_addr (wr_addr),
    .we      (st_we),
    .w_wdata (w_wdata),
    .s_wdata (s_wdata),
    .g_wdata (g_wdata),
    .w_rdata (w_rd),
    .s_rdata (s_rd),
    .g_rdata (g_rd)
  );

  // saturating sums, from the read beat
  assign s_sum  = {1'b0, s_rd} + {1'b0, sq_r};
  assign s_new  = s_sum[64] ? '1 : s_sum[63:0];
  assign gs_sum = {g_rd[47], g_rd} + {{17{it_val[31]}}, it_val};
  always_comb begin
    if (gs_sum[48] != gs_sum[47]) begin
      gs_new = gs_sum[48] ? adl1_pkg::GSUM_MIN : adl1_pkg::GSUM_MAX;
    end else begin
      gs_new = gs_sum[47:0];
    end
  end

  adl1_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (s_new),
    .done  (sq_done),
    .root  (root)
  );

  // step numerator: rate times |g| or rate times the L1 excess
  assign gs_mag  = gs_r[47] ? 48'(-gs_r) : gs_r;
  assign no_gain = {16'b0, gs_mag} <= pen_r;
  assign diff    = 48'({16'b0, gs_mag} - pen_r);
  assign mul_a   = is_plain ? {16'b0, it_mag} : diff;
  assign num     = rate_r * mul_a;

  adl1_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (root),
    .done  (div_done),
    .quo   (quo)
  );

  // plain step: w -/+ d, saturated
  assign nw = {{34{w_old[31]}}, w_old} + (it_val[31] ? {2'b00, quo} : 66'(-{2'b00, quo}));
  always_comb begin
    if (nw[65:31] == '0 || nw[65:31] == '1) begin
      w_plain = nw[31:0];
    end else begin
      w_plain = nw[65] ? adl1_pkg::W_MIN : adl1_pkg::W_MAX;
    end
  end

  // L1 step: sign opposite to the gradient sum, saturated
  assign l1_neg = !gs_r[47] && (gs_r != '0) && (quo != '0);
  always_comb begin
    if (l1_neg) begin
      w_l1 = (quo >= 64'h8000_0000) ? adl1_pkg::W_MIN : 32'(-quo[31:0]);
    end else begin
      w_l1 = (quo > 64'h7FFF_FFFF) ? adl1_pkg::W_MAX : quo[31:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      adl1_pkg::S_CLEAR: if (clr_ptr == AW'(ELEM_COUNT - 1)) state_next = adl1_pkg::S_IDLE;
      adl1_pkg::S_IDLE:  if (acc) state_next = adl1_pkg::S_READ;
      adl1_pkg::S_READ:  state_next = is_update ? adl1_pkg::S_ROOT : adl1_pkg::S_WRITE;
      adl1_pkg::S_ROOT:  if (sq_done) state_next = adl1_pkg::S_PREP;
      adl1_pkg::S_PREP: begin
        if ((!is_plain && no_gain) || root == '0) begin
          state_next = adl1_pkg::S_WRITE;
        end else begin
          state_next = adl1_pkg::S_DIV;
        end
      end
      adl1_pkg::S_DIV:   if (div_done) state_next = adl1_pkg::S_CALC;
      adl1_pkg::S_CALC:  state_next = adl1_pkg::S_WRITE;
      adl1_pkg::S_WRITE: if (out_free) state_next = adl1_pkg::S_IDLE;
      default:           state_next = adl1_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    sq_start  = 1'b0;
    div_start = 1'b0;
    st_we     = '0;
    wr_addr   = AW'(it_idx);
    w_wdata   = res_w;
    s_wdata   = s_new;
    g_wdata   = gs_new;
    unique case (state)
      adl1_pkg::S_CLEAR: begin
        st_we   = '{w: 1'b1, s: 1'b1, g: 1'b1};
        wr_addr = clr_ptr;
        w_wdata = '0;
        s_wdata = '0;
        g_wdata = '0;
      end
      adl1_pkg::S_IDLE: in_ready = 1'b1;
      adl1_pkg::S_READ: begin
        if (is_update) begin
          sq_start = 1'b1;
          st_we.s  = 1'b1;
          st_we.g  = 1'b1;
        end
      end
      adl1_pkg::S_PREP: begin
        div_start = !(!is_plain && no_gain) && root != '0;
      end
      adl1_pkg::S_WRITE: st_we.w = res_wr && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= adl1_pkg::S_CLEAR;
      clr_ptr  <= '0;
      pass_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == adl1_pkg::S_CLEAR) begin
        clr_ptr <= clr_ptr + AW'(1);
      end
      if (acc && starts_pass && pass_cnt != '1) begin
        pass_cnt <= pass_cnt + 32'd1;
      end
    end
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    if (acc) begin
      it_op       <= op;
      it_idx      <= elem_index;
      it_val      <= value;
      it_mag      <= mag_in;
      it_in_range <= 32'(elem_index) < 32'(ELEM_COUNT);
      sq_r        <= mag_in * mag_in;
    end
    unique case (state)
      adl1_pkg::S_READ: begin
        w_old    <= w_rd;
        gs_r     <= gs_new;
        pen_r    <= pass_cnt * l1_r;
        res_w    <= (it_in_range && it_op == adl1_pkg::OP_LOAD) ? it_val : '0;
        res_zero <= 1'b0;
        res_wr   <= it_in_range;
      end
      adl1_pkg::S_PREP: begin
        if (!is_plain && no_gain) begin
          res_w    <= '0;
          res_zero <= 1'b1;
        end else if (root == '0) begin
          res_w    <= is_plain ? w_old : '0;
          res_zero <= 1'b0;
        end
      end
      adl1_pkg::S_CALC: begin
        if (is_plain) begin
          res_w    <= w_plain;
          res_zero <= 1'b0;
        end else if (is_nonneg && l1_neg) begin
          res_w    <= '0;
          res_zero <= 1'b1;
        end else begin
          res_w    <= w_l1;
          res_zero <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == adl1_pkg::S_WRITE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == adl1_pkg::S_WRITE && out_free) begin
      out_index  <= it_idx;
      new_weight <= res_w;
      zeroed     <= res_zero;
    end
  end

`ifndef NO_ASSERTIONS
  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    acc |=> !in_ready)
    else $error("beat accepted while an item is in flight");

  // a finished item always lands in the output register
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == adl1_pkg::S_WRITE && out_free) |=> out_valid)
    else $error("result lost at write-back");

  // a zeroed result carries a zero weight
  a_zero_weight: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zeroed) |-> new_weight == '0)
    else $error("zeroed flag with nonzero weight");

  // the divider starts only in setup, never together with the root
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !sq_start && state == adl1_pkg::S_PREP)
    else $error("divider started outside setup");
`endif

endmodule

[verif/adagrad_l1_element_update_core_test.sv]
`timescale 1ns / 1ps

module adagrad_l1_element_update_core_test;

  localparam int VLEN = 4096;

  typedef struct {
    logic [11:0] idx;
    logic [31:0] w;
    logic        z;
  } weight_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               op;
  logic [11:0]        elem_index;
  logic signed [31:0] value;
  logic               starts_pass;
  logic               out_valid;
  logic               out_ready;
  logic [11:0]        out_index;
  logic signed [31:0] new_weight;
  logic               zeroed;

  adagrad_l1_element_update_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .elem_index(elem_index),
    .value(value), .starts_pass(starts_pass),
    .out_valid(out_valid), .out_ready(out_ready), .out_index(out_index),
    .new_weight(new_weight), .zeroed(zeroed)
  );

  always #10 clk = ~clk;

  // shadow copy of the block state
  logic [1:0]         mode_q;
  logic [15:0]        rate_q;
  logic [31:0]        l1_q;
  logic [31:0]        pass_cnt;
  logic signed [31:0] weight_mem [VLEN];
  logic [63:0]        sqsum_mem [VLEN];
  longint             gsum_mem [VLEN];

  weight_result_t expected_weights [$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int zeroed_seen = 0;
  bit tx_jitter = 1'b1;
  bit rx_jitter = 1'b1;
  int hold_left = 0;

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return adl1_pkg::W_MAX;
    if (v < -64'sd2147483648) return adl1_pkg::W_MIN;
    return v[31:0];
  endfunction

  // next weight of one element, updating the shadow state
  function automatic weight_result_t apply_item(logic o, logic [11:0] ix,
                                                logic signed [31:0] v, logic sp);
    weight_result_t res;
    longint sv, gs, nw;
    logic [63:0] mag, sq, s, r, d, msum, pen, q;
    res.idx = ix;
    res.w = 0;
    res.z = 0;
    if (sp && pass_cnt != 32'hFFFF_FFFF) pass_cnt++;
    if (o == adl1_pkg::OP_LOAD) begin
      weight_mem[ix] = v;
      res.w = v;
    end else begin
      sv = v;
      mag = (sv < 0) ? -sv : sv;
      sq = mag * mag;
      s = sqsum_mem[ix];
      s = (s > ~64'd0 - sq) ? ~64'd0 : s + sq;
      sqsum_mem[ix] = s;
      gs = gsum_mem[ix] + sv;
      if (gs > 64'sh7FFF_FFFF_FFFF) gs = 64'sh7FFF_FFFF_FFFF;
      if (gs < -64'sh8000_0000_0000) gs = -64'sh8000_0000_0000;
      gsum_mem[ix] = gs;
      r = root64(s);
      if (mode_q == adl1_pkg::MODE_PLAIN) begin
        d = (r == 0) ? 64'd0 : (64'(rate_q) * mag) / r;
        nw = weight_mem[ix];
        if (sv < 0) nw = nw + longint'(d);
        else nw = nw - longint'(d);
        res.w = clip32(nw);
      end else begin
        msum = (gs < 0) ? -gs : gs;
        pen = 64'(pass_cnt) * 64'(l1_q);
        if (msum <= pen) begin
          res.z = 1;
        end else begin
          q = (r == 0) ? 64'd0 : (64'(rate_q) * (msum - pen)) / r;
          res.w = (gs > 0) ? clip32(-longint'(q)) : clip32(longint'(q));
          if (mode_q == adl1_pkg::MODE_L1_NONNEG && res.w[31]) begin
            res.w = 0;
            res.z = 1;
          end
        end
      end
      weight_mem[ix] = res.w;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (beat %0d)", what, got, want, beats_checked);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    weight_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_weights.size() == 0) begin
        report_mismatch("unexpected beat", out_index, 0);
      end else begin
        e = expected_weights.pop_front();
        if (out_index !== e.idx) report_mismatch("out_index", out_index, e.idx);
        if (new_weight !== e.w) report_mismatch("new_weight", new_weight, e.w);
        if (zeroed !== e.z) report_mismatch("zeroed", zeroed, e.z);
        if (e.z) zeroed_seen++;
      end
      beats_checked++;
    end
  end

  // receiver: random stall bursts plus a requested long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
        @(posedge clk);
      end else if (rx_jitter && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(logic o, logic [11:0] ix, logic signed [31:0] v, logic sp);
    in_valid <= 1'b1;
    op <= o;
    elem_index <= ix;
    value <= v;
    starts_pass <= sp;
    do @(posedge clk); while (!in_ready);
    expected_weights.insert(expected_weights.size(), apply_item(o, ix, v, sp));
    beats_sent++;
    if (tx_jitter && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_weights.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] ix, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (ix)
      adl1_pkg::REG_MODE: mode_q = data[1:0];
      adl1_pkg::REG_RATE: rate_q = data[15:0];
      adl1_pkg::REG_L1:   l1_q = data;
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_grad();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return 0;
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  task automatic run_random(int n, int span);
    logic [11:0] ix;
    repeat (n) begin
      ix = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, span)) : 12'($urandom());
      send_beat(($urandom_range(0, 7) == 0) ? adl1_pkg::OP_LOAD : adl1_pkg::OP_UPDATE,
                ix, rand_grad(), $urandom_range(0, 15) == 0);
    end
  endtask

  // reset-value registers, field extremes and the special cases
  task automatic test_corner_items();
    send_beat(adl1_pkg::OP_UPDATE, 12'd0, 0, 1'b0);              // zero squared sum under L1
    send_beat(adl1_pkg::OP_UPDATE, 12'd1, 32'sh0001_0000, 1'b0); // above the penalty
    send_beat(adl1_pkg::OP_UPDATE, 12'd2, -32'sh0004_0000, 1'b1);
    send_beat(adl1_pkg::OP_UPDATE, 12'd4095, 32'sh7FFF_FFFF, 1'b0);
    send_beat(adl1_pkg::OP_UPDATE, 12'd4095, 32'sh7FFF_FFFF, 1'b0);
    send_beat(adl1_pkg::OP_UPDATE, 12'd4094, 32'sh8000_0000, 1'b0);
    send_beat(adl1_pkg::OP_LOAD, 12'd3, 32'sh7FFF_FFFF, 1'b1);   // pass flag on a load
    send_beat(adl1_pkg::OP_LOAD, 12'd5, 32'sh8000_0000, 1'b0);
    wait_drained();
    write_reg(adl1_pkg::REG_MODE, {30'h3FFF_FFFF, adl1_pkg::MODE_PLAIN});
    write_reg(adl1_pkg::REG_RATE, 32'hFFFF_FFFF);
    send_beat(adl1_pkg::OP_UPDATE, 12'd3, 32'sh0000_0001, 1'b0); // tiny gradient on max weight
    send_beat(adl1_pkg::OP_UPDATE, 12'd5, -32'sh0000_0001, 1'b0);
    send_beat(adl1_pkg::OP_UPDATE, 12'd6, 0, 1'b0);              // plain mode, zero sum
    send_beat(adl1_pkg::OP_UPDATE, 12'd4095, -32'sh0001_0000, 1'b0);
    wait_drained();
    write_reg(adl1_pkg::REG_MODE, 32'(adl1_pkg::MODE_L1_NONNEG));
    write_reg(adl1_pkg::REG_L1, 32'd0);
    send_beat(adl1_pkg::OP_UPDATE, 12'd7, -32'sh0002_0000, 1'b0); // positive weight kept
    send_beat(adl1_pkg::OP_UPDATE, 12'd8, 32'sh0002_0000, 1'b0);  // negative weight clamped
    wait_drained();
    write_reg(adl1_pkg::REG_RATE, 32'd1);
    send_beat(adl1_pkg::OP_UPDATE, 12'd9, 32'sh0000_0100, 1'b0);  // one-LSB negative weight, clamped to zero
    wait_drained();
    write_reg(adl1_pkg::REG_MODE, 32'd3);                          // acts as L1 mode
    write_reg(adl1_pkg::REG_L1, 32'hFFFF_FFFF);
    send_beat(adl1_pkg::OP_UPDATE, 12'd10, 32'sh7FFF_FFFF, 1'b1);
    send_beat(adl1_pkg::OP_UPDATE, 12'd10, -32'sh0001_0000, 1'b0);
    wait_drained();
  endtask

  // several register settings, extremes included
  task automatic test_config_sweep();
    for (int p = 0; p < 8; p++) begin
      write_reg(adl1_pkg::REG_MODE, 32'(p % 4));
      write_reg(adl1_pkg::REG_RATE, (p == 1) ? 32'd0 : (p == 2) ? 32'hFFFF : $urandom());
      write_reg(adl1_pkg::REG_L1,
                (p == 3) ? 32'hFFFF_FFFF : (p % 2) ? 32'd0 : $urandom_range(0, 4096));
      run_random(200, (p < 4) ? 15 : 255);
      wait_drained();
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    hold_left = 2000;
    repeat (30) send_beat(adl1_pkg::OP_UPDATE, 12'($urandom_range(0, 7)), rand_grad(), 1'b0);
    wait_drained();
  endtask

  // closing stretch with both sides at full rate
  task automatic test_full_rate();
    tx_jitter = 0;
    rx_jitter = 0;
    write_reg(adl1_pkg::REG_MODE, 32'(adl1_pkg::MODE_L1));
    write_reg(adl1_pkg::REG_L1, 32'd64);
    run_random(200, 31);
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= adl1_pkg::REG_MODE;
    cfg_data <= 0;
    in_valid <= 1'b0;
    op <= adl1_pkg::OP_UPDATE;
    elem_index <= 0;
    value <= 0;
    starts_pass <= 1'b0;
    mode_q = adl1_pkg::MODE_RST;
    rate_q = adl1_pkg::RATE_RST;
    l1_q = adl1_pkg::L1_RST;
    pass_cnt = 0;
    for (int i = 0; i < VLEN; i++) begin
      weight_mem[i] = 0;
      sqsum_mem[i] = 0;
      gsum_mem[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_corner_items();
    test_config_sweep();
    test_backpressure();
    test_full_rate();
    repeat (50) @(posedge clk);
    $display("covered %0d beats sent, %0d results checked, %0d zeroed by L1 or clamp",
             beats_sent, beats_checked, zeroed_seen);
    $display("modes 0-3, rate and l1 extremes, long output stall, full-rate tail");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
